// ===== rtl/ipcpwm_pkg.sv =====
// Shared widths, types, stage counts and register indexes for the inverse
// Park/Clarke PWM duty core. No dependencies.
package ipcpwm_pkg;

   localparam int unsigned VOLT_W       = 16;
   localparam int unsigned ANGLE_BITS   = 16;
   localparam int unsigned QUARTER_W    = ANGLE_BITS - 2;
   localparam int unsigned DUTY_W       = 13;
   localparam int unsigned PWM_PERIOD   = 4800;
   localparam int unsigned SINE_W       = 32;
   localparam int unsigned NUM_W        = 29;

   localparam int unsigned SINE_STAGES  = 4;
   localparam int unsigned XFORM_STAGES = 6;
   localparam int unsigned DIV_STAGES   = DUTY_W;
   localparam int unsigned LATENCY      = SINE_STAGES + XFORM_STAGES + DIV_STAGES;

   localparam int unsigned REQ_W        = 32;
   localparam int unsigned RSP_W        = 40;

   typedef logic [DUTY_W-1:0]        duty_type;
   typedef logic signed [SINE_W-1:0] sine_type;
   typedef logic [NUM_W-1:0]         num_type;

   // scaled phase word handed from the transform to the divider
   typedef struct packed {
      num_type num;
      logic    cap;
   } scaled_type;

   typedef enum logic {
      CSR_SUPPLY = 1'b0,
      CSR_LIMIT  = 1'b1
   } csr_addr_type;

   localparam duty_type          PERIOD_COUNT = DUTY_W'(PWM_PERIOD);
   localparam logic [VOLT_W-1:0] LIMIT_RESET  = 16'd2048;

endpackage

// ===== rtl/ipcpwm_sine.sv =====
// Four-stage fixed-point sine of a turn fraction (odd polynomial over a
// quarter turn, Q30 result). Depends on ipcpwm_pkg.
module ipcpwm_sine (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [ipcpwm_pkg::ANGLE_BITS-1:0]   angle,
   output ipcpwm_pkg::sine_type                sine
);

   localparam int unsigned QW = ipcpwm_pkg::QUARTER_W;
   localparam logic [30:0] SIN_A = 31'd1686629713;
   localparam logic [29:0] SIN_B = 30'd688904866;
   localparam logic [26:0] SIN_C = 27'd76016977;

   // stage A: fold into a quarter turn, square
   logic [QW:0]     k_in;
   logic [2*QW+1:0] ksq_in;
   logic [30:0]     x2_in;
   logic [QW:0]     k_a_ff;
   logic            neg_a_ff;
   logic [30:0]     x2_a_ff;

   always_comb begin
      k_in   = angle[QW] ? ((QW+1)'(1 << QW) - {1'b0, angle[QW-1:0]})
                         : {1'b0, angle[QW-1:0]};
      ksq_in = (2*QW+2)'(k_in) * (2*QW+2)'(k_in);
      x2_in  = 31'(ksq_in) << (30 - 2*QW);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k_a_ff   <= k_in;
         neg_a_ff <= angle[QW+1];
         x2_a_ff  <= x2_in;
      end
   end

   // stage B: inner term B - x2*C
   logic [57:0] p1_in;
   logic [29:0] in1_in;
   logic [QW:0] k_b_ff;
   logic        neg_b_ff;
   logic [30:0] x2_b_ff;
   logic [29:0] in1_b_ff;

   always_comb begin
      p1_in  = 58'(x2_a_ff) * 58'(SIN_C);
      in1_in = SIN_B - 30'(p1_in[57:30]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k_b_ff   <= k_a_ff;
         neg_b_ff <= neg_a_ff;
         x2_b_ff  <= x2_a_ff;
         in1_b_ff <= in1_in;
      end
   end

   // stage C: middle term A - x2*inner
   logic [60:0] p2_in;
   logic [30:0] in2_in;
   logic [QW:0] k_c_ff;
   logic        neg_c_ff;
   logic [30:0] in2_c_ff;

   always_comb begin
      p2_in  = 61'(x2_b_ff) * 61'(in1_b_ff);
      in2_in = SIN_A - p2_in[60:30];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k_c_ff   <= k_b_ff;
         neg_c_ff <= neg_b_ff;
         in2_c_ff <= in2_in;
      end
   end

   // stage D: multiply by x and apply the half-turn sign
   logic [QW+31:0]        p3_in;
   logic [30:0]           mag_in;
   ipcpwm_pkg::sine_type  sine_in;
   ipcpwm_pkg::sine_type  sine_d_ff;

   always_comb begin
      p3_in   = (QW+32)'(k_c_ff) * (QW+32)'(in2_c_ff);
      mag_in  = p3_in[QW+30:QW];
      sine_in = neg_c_ff ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_d_ff <= sine_in;
      end
   end

   assign sine = sine_d_ff;

endmodule

// ===== rtl/ipcpwm_xform.sv =====
// Six-stage inverse Park/Clarke transform, half-supply offset, phase clamp
// and duty numerator scaling for three phases. Depends on ipcpwm_pkg.
module ipcpwm_xform (
   input  logic                                      clock,
   input  logic                                      advance,
   input  logic signed [ipcpwm_pkg::VOLT_W-1:0]      uq,
   input  ipcpwm_pkg::sine_type                      sine,
   input  ipcpwm_pkg::sine_type                      cosine,
   input  logic [ipcpwm_pkg::VOLT_W-1:0]             supply,
   input  logic [ipcpwm_pkg::VOLT_W-1:0]             limit,
   output ipcpwm_pkg::scaled_type [2:0]              scaled
);

   localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

   function automatic logic [32:0] clamp_u(logic signed [36:0] tu, logic [32:0] top);
      logic [32:0] res;
      if (tu[36]) begin
         res = '0;
      end else if (tu[35:0] > {3'd0, top}) begin
         res = top;
      end else begin
         res = tu[32:0];
      end
      return res;
   endfunction

   // stage E: magnitudes of Uq*sin and Uq*cos
   logic [15:0] uq_mag_in;
   logic [30:0] sn_mag_in, cs_mag_in;
   logic [46:0] prod_s_ff, prod_c_ff;
   logic        neg_s_ff, neg_c_ff;

   always_comb begin
      uq_mag_in = uq[15] ? (16'd0 - uq) : uq;
      sn_mag_in = sine[31]   ? 31'(32'd0 - sine)   : sine[30:0];
      cs_mag_in = cosine[31] ? 31'(32'd0 - cosine) : cosine[30:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_s_ff <= 47'(uq_mag_in) * 47'(sn_mag_in);
         prod_c_ff <= 47'(uq_mag_in) * 47'(cs_mag_in);
         neg_s_ff  <= uq[15] ^ sine[31];
         neg_c_ff  <= uq[15] ^ cosine[31];
      end
   end

   // stage F: round to 2^-16 V, alpha takes the negated sine product
   logic [47:0]        rnd_s_in, rnd_c_in;
   logic [32:0]        mag_s_in, mag_c_in;
   logic signed [33:0] alpha_in, beta_in;
   logic signed [33:0] alpha_ff, beta_ff;

   always_comb begin
      rnd_s_in = {1'b0, prod_s_ff} + 48'd8192;
      rnd_c_in = {1'b0, prod_c_ff} + 48'd8192;
      mag_s_in = rnd_s_in[46:14];
      mag_c_in = rnd_c_in[46:14];
      alpha_in = neg_s_ff ? $signed({1'b0, mag_s_in}) : -$signed({1'b0, mag_s_in});
      beta_in  = neg_c_ff ? -$signed({1'b0, mag_c_in}) : $signed({1'b0, mag_c_in});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   // stage G: sqrt3 * |beta|
   logic [31:0]        beta_mag_in;
   logic [62:0]        prod3_ff;
   logic               neg3_ff;
   logic signed [33:0] alpha_g_ff;

   always_comb begin
      beta_mag_in = beta_ff[33] ? 32'(-beta_ff) : 32'(beta_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod3_ff   <= 63'(beta_mag_in) * 63'(SQRT3_Q30);
         neg3_ff    <= beta_ff[33];
         alpha_g_ff <= alpha_ff;
      end
   end

   // stage H: round sqrt3*beta
   logic [63:0]        rnd3_in;
   logic [32:0]        mag3_in;
   logic signed [34:0] s3b_in;
   logic signed [34:0] s3b_ff;
   logic signed [33:0] alpha_h_ff;

   always_comb begin
      rnd3_in = {1'b0, prod3_ff} + 64'd536870912;
      mag3_in = rnd3_in[62:30];
      s3b_in  = neg3_ff ? -$signed({2'b0, mag3_in}) : $signed({2'b0, mag3_in});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3b_ff     <= s3b_in;
         alpha_h_ff <= alpha_g_ff;
      end
   end

   // stage I: doubled phase voltages plus supply offset, clamp to the limit
   logic signed [36:0] s_in, al_in, s3_in;
   logic signed [36:0] tu_in [3];
   logic [32:0]        top_in;
   logic [2:0][32:0]   u_in;
   logic [2:0][32:0]   u_ff;

   always_comb begin
      s_in   = $signed({5'd0, supply, 16'd0});
      al_in  = 37'(alpha_h_ff);
      s3_in  = 37'(s3b_ff);
      top_in = {limit, 17'd0};
      tu_in[0] = (al_in <<< 1) + s_in;
      tu_in[1] = s3_in - al_in + s_in;
      tu_in[2] = s_in - al_in - s3_in;
      for (int p = 0; p < 3; p++) begin
         u_in[p] = clamp_u(tu_in[p], top_in);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff <= u_in;
      end
   end

   // stage J: duty numerator (u*period)/2^17 and the full-duty flag
   logic [45:0]                      prod_in [3];
   ipcpwm_pkg::scaled_type [2:0]     scaled_in;
   ipcpwm_pkg::scaled_type [2:0]     scaled_ff;

   always_comb begin
      for (int p = 0; p < 3; p++) begin
         prod_in[p]       = 46'(u_ff[p]) * 46'(ipcpwm_pkg::PWM_PERIOD);
         scaled_in[p].num = prod_in[p][45:17];
         scaled_in[p].cap = u_ff[p] >= {supply, 17'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

// ===== rtl/ipcpwm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, that turns a
// scaled phase numerator into a PWM compare count. Depends on ipcpwm_pkg.
module ipcpwm_div (
   input  logic                               clock,
   input  logic                               advance,
   input  ipcpwm_pkg::scaled_type             scaled,
   input  logic [ipcpwm_pkg::VOLT_W-1:0]      supply,
   output ipcpwm_pkg::duty_type               duty
);

   localparam int unsigned NS = ipcpwm_pkg::DIV_STAGES;

   ipcpwm_pkg::num_type  rem_ff  [NS-1];
   ipcpwm_pkg::duty_type quot_ff [NS];
   logic                 cap_ff  [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      localparam int unsigned BIT = NS - 1 - g;

      ipcpwm_pkg::num_type  rem_src;
      ipcpwm_pkg::num_type  dsh;
      ipcpwm_pkg::duty_type q_src;
      logic                 cap_src;
      logic                 ge;

      if (g == 0) begin : g_first
         assign rem_src = scaled.num;
         assign q_src   = '0;
         assign cap_src = scaled.cap;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign q_src   = quot_ff[g-1];
         assign cap_src = cap_ff[g-1];
      end

      assign dsh = ipcpwm_pkg::NUM_W'(supply) << BIT;
      assign ge  = rem_src >= dsh;

      always_ff @(posedge clock) begin
         if (advance) begin
            quot_ff[g] <= q_src | (ge ? (ipcpwm_pkg::duty_type'(1) << BIT) : '0);
            cap_ff[g]  <= cap_src;
         end
      end

      if (g < NS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[g] <= ge ? (rem_src - dsh) : rem_src;
            end
         end
      end
   end

   // zero supply forces zero duty; a phase at or above supply is full duty
   always_comb begin
      if (supply == '0) begin
         duty = '0;
      end else if (cap_ff[NS-1]) begin
         duty = ipcpwm_pkg::PERIOD_COUNT;
      end else begin
         duty = quot_ff[NS-1];
      end
   end

endmodule

// ===== rtl/inverse_park_clarke_pwm_duty_core.sv =====
// Sinusoidal PWM duty core: inverse Park (Ud = 0) and inverse Clarke of a
// quadrature voltage command at an electrical angle, offset by half the supply,
// clamped to the phase limit and scaled to three compare counts of 0..4800.
// Throughput is one word per clock while the skid register is empty: every
// stage holds one word and a new word may enter each cycle. A word passes
// four stages of sine/cosine polynomial, six of transform, offset, clamp and
// scaling, and thirteen of a restoring divider per phase (one compare count
// bit per stage) before the output register. The result sits in an output
// register backed by a one-word skid register; req_tready is just "skid empty",
// so input keeps flowing while a finished word waits and drops only after the
// consumer has stalled. Configuration is taken on any csr_we edge and must
// only change while the core is idle; a zero supply gives all-zero counts.
// Depends on ipcpwm_pkg, ipcpwm_sine, ipcpwm_xform, ipcpwm_div.
module inverse_park_clarke_pwm_duty_core (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: quad_voltage [15:0], elec_angle [31:16]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ipcpwm_pkg::REQ_W-1:0]        req_tdata,
   // rsp_tdata: duty_a [12:0], duty_b [25:13], duty_c [38:26], zero [39]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ipcpwm_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                                csr_we,
   input  ipcpwm_pkg::csr_addr_type            csr_addr,
   input  logic [ipcpwm_pkg::VOLT_W-1:0]       csr_wdata
);

   localparam int unsigned LAT = ipcpwm_pkg::LATENCY;
   localparam int unsigned AW  = ipcpwm_pkg::ANGLE_BITS;
   localparam int unsigned VW  = ipcpwm_pkg::VOLT_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [VW-1:0] supply_ff;
   logic [VW-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= '0;
         limit_ff  <= ipcpwm_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            ipcpwm_pkg::CSR_SUPPLY: supply_ff <= csr_wdata;
            ipcpwm_pkg::CSR_LIMIT:  limit_ff  <= csr_wdata;
            default:                supply_ff <= supply_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline advance and valid tracking
   // ---------------------------------------------------------------
   logic           skid_vld_ff;
   logic           advance;
   logic           accept;
   logic [LAT-1:0] vld_ff;

   // the whole pipeline moves whenever the skid word is free
   assign advance    = !skid_vld_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------------------------------------------------------
   // Sine and cosine (cosine is the sine a quarter turn later)
   // ---------------------------------------------------------------
   logic [AW-1:0]        angle_s;
   logic [AW-1:0]        angle_c;
   ipcpwm_pkg::sine_type sine;
   ipcpwm_pkg::sine_type cosine;

   assign angle_s = req_tdata[VW+AW-1:VW];
   assign angle_c = angle_s + AW'(1 << (AW - 2));

   ipcpwm_sine u_sine (
      .clock   (clock),
      .advance (advance),
      .angle   (angle_s),
      .sine    (sine)
   );

   ipcpwm_sine u_cosine (
      .clock   (clock),
      .advance (advance),
      .angle   (angle_c),
      .sine    (cosine)
   );

   // hold Uq alongside the sine stages
   logic signed [VW-1:0] uq_dly_ff [ipcpwm_pkg::SINE_STAGES];

   always_ff @(posedge clock) begin
      if (advance) begin
         uq_dly_ff[0] <= $signed(req_tdata[VW-1:0]);
         for (int i = 1; i < ipcpwm_pkg::SINE_STAGES; i++) begin
            uq_dly_ff[i] <= uq_dly_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Transform, offset, clamp and duty numerator
   // ---------------------------------------------------------------
   ipcpwm_pkg::scaled_type [2:0] scaled;

   ipcpwm_xform u_xform (
      .clock   (clock),
      .advance (advance),
      .uq      (uq_dly_ff[ipcpwm_pkg::SINE_STAGES-1]),
      .sine    (sine),
      .cosine  (cosine),
      .supply  (supply_ff),
      .limit   (limit_ff),
      .scaled  (scaled)
   );

   // ---------------------------------------------------------------
   // One divider per phase
   // ---------------------------------------------------------------
   ipcpwm_pkg::duty_type duty [3];

   for (genvar p = 0; p < 3; p++) begin : g_phase
      ipcpwm_div u_div (
         .clock   (clock),
         .advance (advance),
         .scaled  (scaled[p]),
         .supply  (supply_ff),
         .duty    (duty[p])
      );
   end

   // ---------------------------------------------------------------
   // Output register with skid word
   // ---------------------------------------------------------------
   logic                          push;
   logic                          take;
   logic [ipcpwm_pkg::RSP_W-1:0]  push_data;
   logic                          out_vld_ff;
   logic [ipcpwm_pkg::RSP_W-1:0]  out_data_ff;
   logic [ipcpwm_pkg::RSP_W-1:0]  skid_data_ff;

   assign push      = advance && vld_ff[LAT-1];
   assign take      = out_vld_ff && rsp_tready;
   assign push_data = {1'b0, duty[2], duty[1], duty[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || take) begin
         // drain the skid word first, else take the pipeline word
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= push;
         end
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || take) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/ipcpwm_check.sv =====
// Port-level checker for the PWM duty core, bound to the top level.
// Depends on ipcpwm_pkg and inverse_park_clarke_pwm_duty_core.
module ipcpwm_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [ipcpwm_pkg::REQ_W-1:0]        req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ipcpwm_pkg::RSP_W-1:0]        rsp_tdata,
   input logic                                csr_we,
   input ipcpwm_pkg::csr_addr_type            csr_addr,
   input logic [ipcpwm_pkg::VOLT_W-1:0]       csr_wdata
);

   localparam int unsigned DW = ipcpwm_pkg::DUTY_W;

   ipcpwm_pkg::duty_type         duty_a, duty_b, duty_c;
   logic [ipcpwm_pkg::VOLT_W-1:0] supply_ff;
   logic [ipcpwm_pkg::VOLT_W-1:0] limit_ff;
   logic                          in_word;

   assign duty_a  = rsp_tdata[DW-1:0];
   assign duty_b  = rsp_tdata[2*DW-1:DW];
   assign duty_c  = rsp_tdata[3*DW-1:2*DW];
   assign in_word = req_tvalid && req_tready;

   // mirror the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= '0;
         limit_ff  <= ipcpwm_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            ipcpwm_pkg::CSR_SUPPLY: supply_ff <= csr_wdata;
            ipcpwm_pkg::CSR_LIMIT:  limit_ff  <= csr_wdata;
            default:                supply_ff <= supply_ff;
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (duty_a <= ipcpwm_pkg::PERIOD_COUNT) &&
                     (duty_b <= ipcpwm_pkg::PERIOD_COUNT) &&
                     (duty_c <= ipcpwm_pkg::PERIOD_COUNT))
      else $error("compare count above PWM period");

   a_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (supply_ff == '0 || limit_ff == '0) |->
         (duty_a == '0) && (duty_b == '0) && (duty_c == '0))
      else $error("nonzero count with zero supply or zero limit");

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed or dropped");

   a_req_known: assert property (@(posedge clock) disable iff (reset)
      in_word |-> !$isunknown(req_tdata))
      else $error("accepted command word carries unknown bits");

endmodule

bind inverse_park_clarke_pwm_duty_core ipcpwm_check u_ipcpwm_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_we     (csr_we),
   .csr_addr   (csr_addr),
   .csr_wdata  (csr_wdata)
);
